// ===== rtl/pdq_pkg.sv =====
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared types and constants for the periodic deadline queue.
// ----------------------------------------------------------------------------
package pdq_pkg;

   localparam int MAX_TASKS_DEF = 16;

   localparam int TASK_W   = 8;
   localparam int PERIOD_W = 16;
   localparam int TIME_W   = 32;
   localparam int STATUS_W = 2;
   localparam int US_W     = 10;
   localparam int PROD_W   = PERIOD_W + US_W;

   localparam logic [US_W-1:0] US_PER_MS = 10'd1000;

   localparam logic REQ_ADD    = 1'b0;
   localparam logic REQ_EXPIRE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [TASK_W-1:0]   task_id;
      logic [PERIOD_W-1:0] period;
      logic [TIME_W-1:0]   deadline;
   } entry_type;

   localparam int ENTRY_W = TASK_W + PERIOD_W + TIME_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== rtl/pdq_ram.sv =====
// ----------------------------------------------------------------------------
// pdq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pdq_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/periodic_deadline_queue_core.sv =====
// ----------------------------------------------------------------------------
// periodic_deadline_queue_core
// Holds up to MAX_TASKS periodic tasks in one RAM, kept in next-deadline
// order with entry 0 as the head. An add transaction computes
// now + period * 1000 (us, modulo 2^32) and inserts the task; an expiry
// transaction dispatches the head, advances its deadline by one period and
// moves it back behind later entries where needed. One transaction is
// handled at a time: req_stall is high from acceptance until the result is
// in the output register. An add makes a single pass over the RAM and an
// expiry a pass that may stop early (one read and one write per cycle, a
// shared pair of deadline comparators), each after a multiply state and an
// add state; a full add or an empty expiry goes straight to the result. The
// result register lets the next transaction be accepted while a result is
// still stalled. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module periodic_deadline_queue_core #(
   parameter int MAX_TASKS = pdq_pkg::MAX_TASKS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [pdq_pkg::TASK_W-1:0]    req_task_id,
   input  logic [pdq_pkg::PERIOD_W-1:0]  req_period_ms,
   input  logic [pdq_pkg::TIME_W-1:0]    req_now_time,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_run_valid,
   output logic [pdq_pkg::TASK_W-1:0]    rsp_run_task,
   output logic                          rsp_arm_valid,
   output logic [pdq_pkg::TIME_W-1:0]    rsp_arm_time,
   output logic [pdq_pkg::STATUS_W-1:0]  rsp_status
);

   import pdq_pkg::*;

   localparam int AW = $clog2(MAX_TASKS);
   localparam int CW = $clog2(MAX_TASKS + 1);

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        idx_ff, idx_in;
   logic                 op_ff, op_in;
   logic [TASK_W-1:0]    job_task_ff, job_task_in;
   logic [PERIOD_W-1:0]  job_period_ff, job_period_in;
   logic [TIME_W-1:0]    base_ff, base_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;
   logic [TIME_W-1:0]    dl_ff, dl_in;
   entry_type            carry_ff, carry_in;
   logic                 placed_ff, placed_in;
   entry_type            head_ff, head_in;
   logic                 res_run_valid_ff, res_run_valid_in;
   logic [TASK_W-1:0]    res_run_task_ff, res_run_task_in;
   status_type           res_status_ff, res_status_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_run_valid_ff;
   logic [TASK_W-1:0]    rsp_run_task_ff;
   logic                 rsp_arm_valid_ff;
   logic [TIME_W-1:0]    rsp_arm_time_ff;
   status_type           rsp_status_ff;
   logic                 load_rsp;

   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   entry_type            ram_wr_data;
   logic [AW-1:0]        ram_rd_addr;
   logic [ENTRY_W-1:0]   ram_rd_raw;
   entry_type            rd_entry;

   logic [CW-1:0]        idx_p1;
   logic [CW-1:0]        idx_m1;
   logic                 at_end;
   logic                 d_lt;
   logic                 d_gt;
   entry_type            new_entry;

   pdq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_TASKS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign rd_entry  = entry_type'(ram_rd_raw);
   assign idx_p1    = idx_ff + CW'(1);
   assign idx_m1    = idx_ff - CW'(1);
   assign at_end    = (idx_ff == count_ff);
   assign new_entry = '{task_id: job_task_ff, period: job_period_ff, deadline: dl_ff};

   // shared deadline comparators for the scan
   assign d_lt = (dl_ff < rd_entry.deadline);
   assign d_gt = (dl_ff > rd_entry.deadline);

   assign req_stall = (state_ff != ST_IDLE);
   assign load_rsp  = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in         = state_ff;
      count_in         = count_ff;
      idx_in           = idx_ff;
      op_in            = op_ff;
      job_task_in      = job_task_ff;
      job_period_in    = job_period_ff;
      base_in          = base_ff;
      prod_in          = prod_ff;
      dl_in            = dl_ff;
      carry_in         = carry_ff;
      placed_in        = placed_ff;
      res_run_valid_in = res_run_valid_ff;
      res_run_task_in  = res_run_task_ff;
      res_status_in    = res_status_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = idx_ff[AW-1:0];
      ram_wr_data      = new_entry;
      ram_rd_addr      = idx_p1[AW-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in            = req_type;
               job_task_in      = req_task_id;
               job_period_in    = req_period_ms;
               base_in          = req_now_time;
               placed_in        = 1'b0;
               res_run_valid_in = 1'b0;
               res_run_task_in  = '0;
               res_status_in    = STATUS_OK;
               if (req_type == REQ_ADD) begin
                  if (count_ff == CW'(MAX_TASKS)) begin
                     res_status_in = STATUS_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_MUL;
                  end
               end else begin
                  if (count_ff == '0) begin
                     res_status_in = STATUS_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     job_task_in      = head_ff.task_id;
                     job_period_in    = head_ff.period;
                     base_in          = head_ff.deadline;
                     res_run_valid_in = 1'b1;
                     res_run_task_in  = head_ff.task_id;
                     state_in         = ST_MUL;
                  end
               end
            end
         end
         ST_MUL: begin
            prod_in  = {{(PROD_W-PERIOD_W){1'b0}}, job_period_ff} *
                       {{(PROD_W-US_W){1'b0}}, US_PER_MS};
            state_in = ST_SUM;
         end
         ST_SUM: begin
            dl_in = base_ff + {{(TIME_W-PROD_W){1'b0}}, prod_ff};
            // add scans from the head, expiry from the entry after it
            if (op_ff == REQ_ADD) begin
               idx_in      = '0;
               ram_rd_addr = '0;
            end else begin
               idx_in      = CW'(1);
               ram_rd_addr = AW'(1);
            end
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            idx_in = idx_p1;
            if (op_ff == REQ_ADD) begin
               // head slot needs strictly earlier, later slots go before the
               // first entry not earlier than the new deadline
               if (!placed_ff && (at_end || ((idx_ff == '0) ? d_lt : !d_gt))) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = new_entry;
                  carry_in    = rd_entry;
                  placed_in   = 1'b1;
               end else if (placed_ff) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = carry_ff;
                  carry_in    = rd_entry;
               end
               if (at_end) begin
                  count_in = count_ff + CW'(1);
                  state_in = ST_DONE;
               end
            end else begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = idx_m1[AW-1:0];
               if (at_end || !d_gt) begin
                  ram_wr_data = new_entry;
                  state_in    = ST_DONE;
               end else begin
                  ram_wr_data = rd_entry;
               end
            end
         end
         ST_DONE: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      head_in = head_ff;
      if (ram_wr_en && (ram_wr_addr == '0)) begin
         head_in = ram_wr_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff           <= idx_in;
      op_ff            <= op_in;
      job_task_ff      <= job_task_in;
      job_period_ff    <= job_period_in;
      base_ff          <= base_in;
      prod_ff          <= prod_in;
      dl_ff            <= dl_in;
      carry_ff         <= carry_in;
      placed_ff        <= placed_in;
      head_ff          <= head_in;
      res_run_valid_ff <= res_run_valid_in;
      res_run_task_ff  <= res_run_task_in;
      res_status_ff    <= res_status_in;
      if (load_rsp) begin
         rsp_run_valid_ff <= res_run_valid_ff;
         rsp_run_task_ff  <= res_run_task_ff;
         rsp_status_ff    <= res_status_ff;
         rsp_arm_valid_ff <= (count_ff != '0);
         rsp_arm_time_ff  <= (count_ff != '0) ? head_ff.deadline : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_run_valid = rsp_run_valid_ff;
   assign rsp_run_task  = rsp_run_task_ff;
   assign rsp_arm_valid = rsp_arm_valid_ff;
   assign rsp_arm_time  = rsp_arm_time_ff;
   assign rsp_status    = rsp_status_ff;

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_TASKS))
      else $error("entry count beyond capacity");

   a_scan_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= count_ff))
      else $error("scan index past entry count");

   a_count_step : assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (count_ff != $past(count_ff))) |->
         (count_ff == $past(count_ff) + CW'(1)))
      else $error("entry count changed by other than one");

   a_full_status : assert property (@(posedge clock) disable iff (reset)
      (load_rsp && (res_status_ff == STATUS_FULL)) |-> (count_ff == CW'(MAX_TASKS)))
      else $error("full reported with free entries");

   a_run_has_arm : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_run_valid_ff) |-> rsp_arm_valid_ff)
      else $error("dispatch reported with empty queue");

endmodule
